/* design/position_window_average_top_macros.svh */
// Assertion macros for the position window average block.
`ifndef POSITION_WINDOW_AVERAGE_TOP_MACROS_SVH
`define POSITION_WINDOW_AVERAGE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define PWA_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pwa check failed");
`define PWA_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pwa check failed");
`else
`define PWA_ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define PWA_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

/* design/pwa_pkg.sv */
`default_nettype none
package pwa_pkg;

  localparam int RING_DEPTH = 32;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int POS_W      = 31;
  localparam int VAL_W      = 32;
  localparam int RES_W      = 37;
  localparam int SUM_W      = RES_W + 1;
  localparam int OCNT_W     = 5;
  localparam int WIN_W      = 31;
  localparam int HALF_W     = WIN_W - 1;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_MODE = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_SIZE_RESET = WIN_W'(200);

  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] sample_value;
    logic                    end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] window_result;
    logic [OCNT_W-1:0]       left_count;
    logic [OCNT_W-1:0]       right_count;
    logic                    window_truncated;
    logic                    last_result;
  } out_item_t;

  typedef struct packed {
    logic                    start;
    logic signed [RES_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [RES_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] pend;
  } eng_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLOSE_RD,
    ST_CLOSE_CHK,
    ST_DROP_RD,
    ST_DROP_CHK,
    ST_PRESS,
    ST_FULL_RD,
    ST_FULL_DO,
    ST_STORE,
    ST_FLUSH,
    ST_EM_CTR_RD,
    ST_EM_CTR,
    ST_EM_LEFT_RD,
    ST_EM_LEFT,
    ST_EM_TRUNC,
    ST_EM_RIGHT_RD,
    ST_EM_RIGHT,
    ST_EM_SAT,
    ST_EM_DIV,
    ST_EM_OUT
  } eng_state_t;

endpackage
`default_nettype wire

/* design/pwa_front.sv */
`default_nettype none
module pwa_front import pwa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          q_valid,
  output in_item_t      q_item,
  input  wire logic     q_pop
);

  in_item_t           mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

/* design/pwa_div.sv */
`default_nettype none
module pwa_div import pwa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEP_W = $clog2(RES_W + 1);

  logic [RES_W-1:0]  quo;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  dvs;
  logic              neg;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem[CNT_W-1:0], quo[RES_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[RES_W-1];
      quo <= req.dividend[RES_W-1] ? RES_W'(-req.dividend) : RES_W'(req.dividend);
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? trial - {1'b0, dvs} : trial;
      quo <= {quo[RES_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(RES_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? -$signed(quo) : $signed(quo);

endmodule
`default_nettype wire

/* design/pwa_engine.sv */
`default_nettype none
module pwa_engine import pwa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [WIN_W-1:0] window_size,
  input  wire logic             average_mode,
  input  wire logic             q_valid,
  input  wire in_item_t         q_item,
  output logic                  q_pop,
  output div_req_t              div_req,
  input  wire div_rsp_t         div_rsp,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  output eng_stat_t             stat
);

  logic [POS_W-1:0] pos_ring [RING_DEPTH];
  logic [VAL_W-1:0] val_ring [RING_DEPTH];

  eng_state_t state, state_next, em_ret;

  in_item_t          cur;
  logic [IDX_W-1:0]  oldest_kept;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  pend;
  logic              drop_valid;
  logic [POS_W-1:0]  drop_pos;
  logic [POS_W-1:0]  ref_pos;

  logic [CNT_W-1:0]        em_off;
  logic [POS_W-1:0]        em_p;
  logic signed [SUM_W-1:0] em_sum;
  logic [CNT_W-1:0]        em_left;
  logic [CNT_W-1:0]        em_k;
  logic                    em_trunc;
  logic                    em_last;
  logic signed [RES_W-1:0] em_res;

  logic [POS_W-1:0]  rd_pos;
  logic [VAL_W-1:0]  rd_val;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;

  logic              em_start;
  logic              em_forced;
  logic              em_last_in;
  eng_state_t        em_ret_in;
  logic              out_load;
  logic              out_free;

  logic [HALF_W-1:0]       half;
  logic [CNT_W-1:0]        pend_off;
  logic [CNT_W-1:0]        right_cnt;
  logic [CNT_W-1:0]        left_idx;
  logic signed [SUM_W-1:0] rd_val_ext;
  logic signed [RES_W-1:0] sat_res;
  logic                    close_beyond;
  logic                    drop_beyond;
  logic                    left_beyond;
  logic                    dropped_near;

  function automatic logic beyond(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b,
                                  input logic [HALF_W-1:0] h);
    logic signed [POS_W:0] diff;
    diff = $signed({1'b0, a}) - $signed({1'b0, b});
    return diff > $signed({2'b00, h});
  endfunction

  assign half         = window_size[WIN_W-1:1];
  assign pend_off     = fill - pend;
  assign right_cnt    = fill - em_off - 1'b1;
  assign left_idx     = em_off - 1'b1 - em_left;
  assign rd_val_ext   = SUM_W'($signed(rd_val));
  assign close_beyond = beyond(cur.position, rd_pos, half);
  assign drop_beyond  = beyond(ref_pos, rd_pos, half);
  assign left_beyond  = beyond(em_p, rd_pos, half);
  assign dropped_near = drop_valid && !beyond(em_p, drop_pos, half);
  assign out_free     = !out_valid || !out_stall;
  assign wr_addr      = oldest_kept + fill[IDX_W-1:0];

  always_comb begin
    if (em_sum[SUM_W-1] != em_sum[RES_W-1]) begin
      sat_res = em_sum[SUM_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      sat_res = em_sum[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_ring[wr_addr] <= cur.position;
      val_ring[wr_addr] <= cur.sample_value;
    end
    rd_pos <= pos_ring[rd_addr];
    rd_val <= val_ring[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (q_valid) state_next = ST_CLOSE_RD;
      ST_CLOSE_RD:  state_next = (pend == '0) ? ST_DROP_RD : ST_CLOSE_CHK;
      ST_CLOSE_CHK: state_next = close_beyond ? ST_EM_CTR_RD : ST_DROP_RD;
      ST_DROP_RD:   state_next = (fill > pend) ? ST_DROP_CHK : ST_PRESS;
      ST_DROP_CHK:  state_next = drop_beyond ? ST_DROP_RD : ST_PRESS;
      ST_PRESS: begin
        state_next = (pend >= CNT_W'(RING_DEPTH - 1)) ? ST_EM_CTR_RD : ST_FULL_RD;
      end
      ST_FULL_RD:   state_next = (fill >= CNT_W'(RING_DEPTH)) ? ST_FULL_DO : ST_STORE;
      ST_FULL_DO:   state_next = ST_STORE;
      ST_STORE:     state_next = cur.end_of_stream ? ST_FLUSH : ST_IDLE;
      ST_FLUSH:     state_next = (pend != '0) ? ST_EM_CTR_RD : ST_IDLE;
      ST_EM_CTR_RD: state_next = ST_EM_CTR;
      ST_EM_CTR:    state_next = (em_off != '0) ? ST_EM_LEFT_RD : ST_EM_TRUNC;
      ST_EM_LEFT_RD: state_next = ST_EM_LEFT;
      ST_EM_LEFT: begin
        if (left_beyond || (em_left + 1'b1 == em_off)) begin
          state_next = ST_EM_TRUNC;
        end else begin
          state_next = ST_EM_LEFT_RD;
        end
      end
      ST_EM_TRUNC:    state_next = (right_cnt != '0) ? ST_EM_RIGHT_RD : ST_EM_SAT;
      ST_EM_RIGHT_RD: state_next = ST_EM_RIGHT;
      ST_EM_RIGHT:    state_next = (em_k == right_cnt) ? ST_EM_SAT : ST_EM_RIGHT_RD;
      ST_EM_SAT:      state_next = average_mode ? ST_EM_DIV : ST_EM_OUT;
      ST_EM_DIV:      if (div_rsp.done) state_next = ST_EM_OUT;
      ST_EM_OUT:      if (out_free) state_next = em_ret;
      default:        state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    rd_addr    = oldest_kept;
    wr_en      = 1'b0;
    em_start   = 1'b0;
    em_forced  = 1'b0;
    em_last_in = 1'b0;
    em_ret_in  = ST_CLOSE_RD;
    out_load   = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sat_res;
    div_req.divisor  = em_left + right_cnt + 1'b1;
    unique case (state)
      ST_IDLE:      q_pop = q_valid;
      ST_CLOSE_RD:  rd_addr = oldest_kept + pend_off[IDX_W-1:0];
      ST_CLOSE_CHK: em_start = close_beyond;
      ST_PRESS: begin
        em_start  = (pend >= CNT_W'(RING_DEPTH - 1));
        em_forced = 1'b1;
        em_ret_in = ST_FULL_RD;
      end
      ST_STORE:     wr_en = 1'b1;
      ST_FLUSH: begin
        em_start   = (pend != '0);
        em_last_in = (pend == CNT_W'(1));
        em_ret_in  = ST_FLUSH;
      end
      ST_EM_CTR_RD:   rd_addr = oldest_kept + em_off[IDX_W-1:0];
      ST_EM_LEFT_RD:  rd_addr = oldest_kept + left_idx[IDX_W-1:0];
      ST_EM_RIGHT_RD: rd_addr = oldest_kept + em_off[IDX_W-1:0] + em_k[IDX_W-1:0];
      ST_EM_SAT:      div_req.start = average_mode;
      ST_EM_OUT:      out_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur <= q_item;
    end
    if (state == ST_CLOSE_RD && pend == '0) begin
      ref_pos <= cur.position;
    end
    if (state == ST_CLOSE_CHK && !close_beyond) begin
      ref_pos <= rd_pos;
    end
    if (state == ST_FULL_DO) begin
      drop_pos <= rd_pos;
    end
    if (em_start) begin
      em_off   <= pend_off;
      em_trunc <= em_forced;
      em_last  <= em_last_in;
      em_ret   <= em_ret_in;
    end
    unique case (state)
      ST_EM_CTR: begin
        em_p    <= rd_pos;
        em_sum  <= rd_val_ext;
        em_left <= '0;
      end
      ST_EM_LEFT: begin
        if (!left_beyond) begin
          em_sum  <= em_sum + rd_val_ext;
          em_left <= em_left + 1'b1;
        end
      end
      ST_EM_TRUNC: begin
        if (em_left == em_off && dropped_near) begin
          em_trunc <= 1'b1;
        end
        em_k <= CNT_W'(1);
      end
      ST_EM_RIGHT: begin
        em_sum <= em_sum + rd_val_ext;
        em_k   <= em_k + 1'b1;
      end
      ST_EM_SAT: em_res <= sat_res;
      ST_EM_DIV: if (div_rsp.done) em_res <= div_rsp.quotient;
      default: begin
      end
    endcase
    if (out_load) begin
      out_data.window_result    <= em_res;
      out_data.left_count       <= em_left[OCNT_W-1:0];
      out_data.right_count      <= right_cnt[OCNT_W-1:0];
      out_data.window_truncated <= em_trunc;
      out_data.last_result      <= em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      oldest_kept <= '0;
      fill        <= '0;
      pend        <= '0;
      drop_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        pend      <= pend - 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_DROP_CHK: begin
          if (drop_beyond) begin
            oldest_kept <= oldest_kept + 1'b1;
            fill        <= fill - 1'b1;
          end
        end
        ST_FULL_DO: begin
          drop_valid  <= 1'b1;
          oldest_kept <= oldest_kept + 1'b1;
          fill        <= fill - 1'b1;
        end
        ST_STORE: begin
          fill <= fill + 1'b1;
          pend <= pend + 1'b1;
        end
        ST_FLUSH: begin
          if (pend == '0) begin
            oldest_kept <= '0;
            fill        <= '0;
            drop_valid  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.fill = fill;
  assign stat.pend = pend;

endmodule
`default_nettype wire

/* design/position_window_average_top.sv */
// Position window average: moving rectangular-window sum or average over a
// stream of (position, value) items.
// Input channel in_valid/in_stall/in_data carries one item per transfer; the
// item with end_of_stream set flushes every pending result.
// Output channel out_valid/out_stall/out_data carries one result per transfer,
// in stream order; one item may release none, one or many results.
// Configuration: cfg_we with cfg_index and cfg_data writes window_size
// (index 0) or average_mode (index 1); write only while the block is idle.
// Per item, the engine checks the oldest pending entry against it, drops
// stored items beyond the window from the front of the ring one at a time,
// stores the item, and with end_of_stream also flushes. Each result reads
// its center, left neighbors and right neighbors one at a time through the
// single read port of the ring memory, then uses the serial divider in
// average mode.
// A two-entry queue takes items while earlier ones are still worked on.
// Reset clears the queue, ring bookkeeping and output register, and sets
// window_size to 200 and average_mode to 0; no clearing pass is needed.
// When out_stall is high the result holds, the engine waits, and the input
// queue fills up and raises in_stall.
`default_nettype none
`include "position_window_average_top_macros.svh"
module position_window_average_top import pwa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WIN_W-1:0] window_size;
  logic             average_mode;
  logic             q_valid;
  in_item_t         q_item;
  logic             q_pop;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  eng_stat_t        stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= WINDOW_SIZE_RESET;
      average_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE:  window_size  <= cfg_data[WIN_W-1:0];
        CFG_AVERAGE_MODE: average_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pwa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pwa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pwa_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .window_size  (window_size),
    .average_mode (average_mode),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .stat         (stat)
  );

  `PWA_ASSERT_IMPL(a_pend_le_fill, clk, rst, 1'b1, stat.pend <= stat.fill)
  `PWA_ASSERT_IMPL(a_fill_le_depth, clk, rst, 1'b1, stat.fill <= CNT_W'(RING_DEPTH))
  `PWA_ASSERT_IMPL(a_pend_room, clk, rst, 1'b1, stat.pend <= CNT_W'(RING_DEPTH - 1))
  `PWA_ASSERT_NEXT(a_queue_holds, clk, rst, in_valid && !in_stall, q_valid)

endmodule
`default_nettype wire
